// ----- sv/fbfla_pkg.sv -----
// Shared types, constants and helpers for the fixed block free list allocator.
`default_nettype none

package fbfla_pkg;

  // Pool geometry
  localparam int MAX_BLOCKS  = 1024;
  localparam int BLOCK_BYTES = 64;   // power of two: offsets split by shift and mask
  localparam int BATCH       = 16;

  localparam int LINK_W    = $clog2(MAX_BLOCKS + 1);
  localparam int ADDR_W    = $clog2(MAX_BLOCKS);
  localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);

  // Fixed field widths
  localparam int CNT_W      = 11;
  localparam int OFF_W      = 32;
  localparam int BASE_W     = 16;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int REQ_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int IDX_W      = OFF_W - BLK_SHIFT;

  localparam logic [LINK_W-1:0] NULL_LINK     = LINK_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0]  CNT_MAX       = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0]  GIVE_BACK_LVL = CNT_W'(2 * BATCH);
  localparam logic [BASE_W-1:0] BASE_RESET    = BASE_W'(64);

  typedef enum logic [REQ_W-1:0] {
    REQ_FORMAT = 2'd0,
    REQ_ALLOC  = 2'd1,
    REQ_FREE   = 2'd2
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_MEM    = 2'd1,
    ST_TOO_SMALL = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_SIZE  = 1'd0,
    CFG_FIRST_OFFSET = 1'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_EXEC
  } fsm_t;

  // Saturating count helpers
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v >= CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] v);
    sat_dec = (v == '0) ? v : v - CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

// ----- sv/fixed_block_free_list_allocator.sv -----
// Fixed-size block allocator with a global free list and a local cache list.
//
// Channels: the request channel (in_valid / in_stall) carries req_type and
// block_offset; the result channel (out_valid / out_stall) returns one result
// transaction per request: status, granted offset and both list counts after
// the request. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_data); the user must write it only while no request is in flight.
// The block does not enforce this. Throughput: one request at a time.
// Allocate, free and rejected requests are accepted in S_IDLE and committed
// in S_EXEC; an allocate reads the link memory's registered port on accept.
// A successful format first sweeps the link memory, one entry per cycle.
// The result sits in an output register; the commit cycle waits while that
// register still holds an untaken result and out_stall is high.
// Reset: empty lists, zero counts, region_size 0, first_block_offset 64.
// The link memory is not cleared; format writes every entry it later uses.
`default_nettype none

module fixed_block_free_list_allocator import fbfla_pkg::*; (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_we,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [CFG_W-1:0]      cfg_data,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire  [REQ_W-1:0]      in_req_type,
  input  wire  [OFF_W-1:0]      in_block_offset,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [OFF_W-1:0]      out_granted_offset,
  output logic [CNT_W-1:0]      out_global_free,
  output logic [CNT_W-1:0]      out_local_free
);

  // Configuration registers
  logic [OFF_W-1:0]  region_size_r;
  logic [BASE_W-1:0] base_r;

  // Control state
  fsm_t              state_r, state_nxt;
  logic [LINK_W-1:0] gh_r, gh_nxt;
  logic [LINK_W-1:0] lh_r, lh_nxt;
  logic [CNT_W-1:0]  gc_r, gc_nxt;
  logic [CNT_W-1:0]  lc_r, lc_nxt;
  logic [CNT_W-1:0]  pool_r, pool_nxt;
  logic              out_valid_r;

  // Latched request
  logic [REQ_W-1:0]  req_r;
  logic [OFF_W-1:0]  boff_r;
  logic              fmt_ok_r;
  logic [CNT_W-1:0]  fmt_n_r;
  logic [ADDR_W-1:0] sweep_idx_r;

  // Output payload registers
  logic [STATUS_W-1:0] out_status_r;
  logic [OFF_W-1:0]    out_granted_r;
  logic [CNT_W-1:0]    out_gfree_r;
  logic [CNT_W-1:0]    out_lfree_r;

  // Link memory
  logic [LINK_W-1:0] link_mem [MAX_BLOCKS];
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [LINK_W-1:0] mem_wdata, rd_data_r;

  logic              in_acc, out_free, commit, sweep_last;
  logic              fmt_small;
  logic [OFF_W-1:0]  fmt_diff;
  logic [IDX_W-1:0]  fmt_raw;
  logic [CNT_W-1:0]  fmt_n;

  // Commit results
  logic [STATUS_W-1:0] res_status;
  logic [OFF_W-1:0]    res_granted;

  // Free request decode
  logic              free_ge, free_ok, give_back;
  logic [OFF_W-1:0]  free_rel;
  logic [IDX_W-1:0]  free_idx;
  logic [CNT_W-1:0]  lc_inc;

  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign commit     = (state_r == S_EXEC) && out_free;
  assign sweep_last = ({1'b0, sweep_idx_r} == (fmt_n_r - CNT_W'(1)));

  // Format geometry from the live configuration
  assign fmt_small = ({1'b0, region_size_r} <
                      ((OFF_W+1)'(base_r) + (OFF_W+1)'(BLOCK_BYTES)));
  assign fmt_diff  = region_size_r - OFF_W'(base_r);
  assign fmt_raw   = fmt_diff[OFF_W-1:BLK_SHIFT];
  assign fmt_n     = (fmt_raw > IDX_W'(MAX_BLOCKS)) ? CNT_MAX : fmt_raw[CNT_W-1:0];

  // Free offset check
  assign free_ge   = (boff_r >= OFF_W'(base_r));
  assign free_rel  = boff_r - OFF_W'(base_r);
  assign free_idx  = free_rel[OFF_W-1:BLK_SHIFT];
  assign free_ok   = free_ge && (free_rel[BLK_SHIFT-1:0] == '0) &&
                     (free_idx < IDX_W'(pool_r));
  assign lc_inc    = sat_inc(lc_r);
  assign give_back = (lc_inc >= GIVE_BACK_LVL);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_size_r <= '0;
      base_r        <= BASE_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_REGION_SIZE:  region_size_r <= cfg_data;
        CFG_FIRST_OFFSET: base_r        <= cfg_data[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if ((req_t'(in_req_type) == REQ_FORMAT) && !fmt_small) state_nxt = S_SWEEP;
          else state_nxt = S_EXEC;
        end
      end
      S_SWEEP: begin
        if (sweep_last) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs: memory control, list updates and result
  always_comb begin
    in_stall    = (state_r != S_IDLE);
    mem_re      = 1'b0;
    mem_raddr   = lh_r[ADDR_W-1:0];
    mem_we      = 1'b0;
    mem_waddr   = sweep_idx_r;
    mem_wdata   = sweep_last ? NULL_LINK : LINK_W'(sweep_idx_r) + LINK_W'(1);
    gh_nxt      = gh_r;
    lh_nxt      = lh_r;
    gc_nxt      = gc_r;
    lc_nxt      = lc_r;
    pool_nxt    = pool_r;
    res_status  = ST_OK;
    res_granted = '0;
    case (state_r)
      S_IDLE: begin
        // Fetch the link of the block an allocate will touch
        if (in_acc && (req_t'(in_req_type) == REQ_ALLOC)) begin
          if (lh_r != NULL_LINK) begin
            mem_re    = 1'b1;
            mem_raddr = lh_r[ADDR_W-1:0];
          end else if (gh_r != NULL_LINK) begin
            mem_re    = 1'b1;
            mem_raddr = gh_r[ADDR_W-1:0];
          end
        end
      end
      S_SWEEP: begin
        // Chain block i to block i + 1, last block to null
        mem_we = 1'b1;
      end
      S_EXEC: begin
        if (commit) begin
          case (req_t'(req_r))
            REQ_FORMAT: begin
              if (!fmt_ok_r) begin
                res_status = ST_TOO_SMALL;
              end else begin
                gh_nxt   = '0;
                gc_nxt   = fmt_n_r;
                lh_nxt   = NULL_LINK;
                lc_nxt   = '0;
                pool_nxt = fmt_n_r;
              end
            end
            REQ_ALLOC: begin
              if (lh_r != NULL_LINK) begin
                // Pop the local list
                lh_nxt      = rd_data_r;
                lc_nxt      = sat_dec(lc_r);
                res_granted = OFF_W'(base_r) +
                              (OFF_W'(lh_r[ADDR_W-1:0]) << BLK_SHIFT);
              end else if (gh_r != NULL_LINK) begin
                // Move the global head over, then pop it straight away
                mem_we      = 1'b1;
                mem_waddr   = gh_r[ADDR_W-1:0];
                mem_wdata   = lh_r;
                gh_nxt      = rd_data_r;
                gc_nxt      = sat_dec(gc_r);
                lc_nxt      = sat_dec(lc_inc);
                res_granted = OFF_W'(base_r) +
                              (OFF_W'(gh_r[ADDR_W-1:0]) << BLK_SHIFT);
              end else begin
                res_status = ST_NO_MEM;
              end
            end
            REQ_FREE: begin
              if (free_ok) begin
                mem_we    = 1'b1;
                mem_waddr = free_idx[ADDR_W-1:0];
                if (give_back) begin
                  // Pushed block goes on to the global list at once
                  mem_wdata = gh_r;
                  gh_nxt    = LINK_W'(free_idx[ADDR_W-1:0]);
                  gc_nxt    = sat_inc(gc_r);
                  lc_nxt    = sat_dec(lc_inc);
                end else begin
                  mem_wdata = lh_r;
                  lh_nxt    = LINK_W'(free_idx[ADDR_W-1:0]);
                  lc_nxt    = lc_inc;
                end
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Link memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= link_mem[mem_raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gh_r        <= NULL_LINK;
      lh_r        <= NULL_LINK;
      gc_r        <= '0;
      lc_r        <= '0;
      pool_r      <= '0;
      out_valid_r <= 1'b0;
      sweep_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      gh_r    <= gh_nxt;
      lh_r    <= lh_nxt;
      gc_r    <= gc_nxt;
      lc_r    <= lc_nxt;
      pool_r  <= pool_nxt;
      if (commit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (in_acc) sweep_idx_r <= '0;
      else if (state_r == S_SWEEP) sweep_idx_r <= sweep_idx_r + ADDR_W'(1);
    end
  end

  // Latch the request and format geometry
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r    <= in_req_type;
      boff_r   <= in_block_offset;
      fmt_ok_r <= !fmt_small;
      fmt_n_r  <= fmt_n;
    end
  end

  // Load the result transaction
  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r  <= res_status;
      out_granted_r <= res_granted;
      out_gfree_r   <= gc_nxt;
      out_lfree_r   <= lc_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_offset = out_granted_r;
  assign out_global_free    = out_gfree_r;
  assign out_local_free     = out_lfree_r;

endmodule

`default_nettype wire

// ----- sv/fbfla_checker.sv -----
// Port-level checks for the fixed block free list allocator, bound to the top level.
`default_nettype none

module fbfla_port_checker import fbfla_pkg::*; (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_stall,
  input wire                 out_valid,
  input wire                 out_stall,
  input wire [STATUS_W-1:0]  out_status,
  input wire [OFF_W-1:0]     out_granted_offset,
  input wire [CNT_W-1:0]     out_global_free,
  input wire [CNT_W-1:0]     out_local_free
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_granted_offset) && $stable(out_global_free) && $stable(out_local_free))
    else $error("stalled result changed");

  // Drop any result during reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Counts never pass the pool cap
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_global_free <= CNT_W'(MAX_BLOCKS)) &&
      (out_local_free <= CNT_W'(MAX_BLOCKS)))
    else $error("free count above pool cap");

  // Failed requests grant nothing
  a_err_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NO_MEM || out_status == ST_TOO_SMALL) |->
      (out_granted_offset == '0))
    else $error("granted offset on failed request");

  // One request at a time: stall right after an accepted transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

endmodule

bind fixed_block_free_list_allocator fbfla_port_checker u_fbfla_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_granted_offset (out_granted_offset),
  .out_global_free    (out_global_free),
  .out_local_free     (out_local_free)
);

`default_nettype wire
